@@ hw/rtl/dcci_pkg.sv @@
// ----------------------------------------------------------------------------
// dcci_pkg
// Shared types and codes for the DMA command cluster interleaver.
// ----------------------------------------------------------------------------
package dcci_pkg;

  localparam int PAYLOAD_W   = 64;
  localparam int DIR_W       = 3;
  localparam int CLU_W       = 4;
  localparam int CLUSTER_IDS = 16;
  localparam int MASK_W      = 8;

  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_END    = 1'b1;
  localparam logic KIND_DMA   = 1'b0;
  localparam logic KIND_OTHER = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_MASK = 1'b0;
  localparam logic REG_LOOP = 1'b1;

  typedef struct packed {
    logic                 flush_pre;
    logic                 append;
    logic                 flush_post;
    logic                 emit;
    logic                 kind;
    logic [DIR_W-1:0]     direction;
    logic [CLU_W-1:0]     cluster;
    logic [PAYLOAD_W-1:0] payload;
  } op_t;

endpackage

@@ hw/rtl/dcci_if.sv @@
// ----------------------------------------------------------------------------
// dcci_if
// Valid/ready stream interfaces for command input and segment output.
// ----------------------------------------------------------------------------
interface dcci_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        seg_kind;
  logic [2:0]  direction;
  logic [3:0]  cluster;
  logic [63:0] payload;

  modport source (output valid, cmd, seg_kind, direction, cluster, payload, input ready);
  modport sink   (input valid, cmd, seg_kind, direction, cluster, payload, output ready);
endinterface

interface dcci_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [2:0]  out_direction;
  logic [3:0]  out_cluster;
  logic [63:0] out_payload;
  logic        last;

  modport source (output valid, out_kind, out_direction, out_cluster, out_payload, last,
                  input ready);
  modport sink   (input valid, out_kind, out_direction, out_cluster, out_payload, last,
                  output ready);
endinterface

@@ hw/rtl/dcci_ram.sv @@
// ----------------------------------------------------------------------------
// dcci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hw/rtl/dcci_front.sv @@
// ----------------------------------------------------------------------------
// dcci_front
// Classifies incoming commands into back-end operations; tracks run state.
// ----------------------------------------------------------------------------
module dcci_front #(
  parameter int RUN_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dcci_in_if.sink                       in_s,
  input  logic [dcci_pkg::DIR_W-1:0]    loop_dir,
  output dcci_pkg::op_t                 op,
  output logic                          op_valid,
  input  logic                          op_ready
);

  localparam int CW = $clog2(RUN_DEPTH + 1);

  logic [CW-1:0]              count_r, count_nxt;
  logic [dcci_pkg::DIR_W-1:0] rdir_r, rdir_nxt;
  logic                       skip_r, skip_nxt;
  logic [CW-1:0]              base;
  logic                       accept;

  assign in_s.ready = op_ready;
  assign accept     = in_s.valid && op_ready;
  assign op_valid   = in_s.valid;

  always_comb begin
    op            = '0;
    op.payload    = in_s.payload;
    count_nxt     = count_r;
    rdir_nxt      = rdir_r;
    skip_nxt      = skip_r;
    base          = count_r;
    if (in_s.cmd == dcci_pkg::CMD_END) begin
      op.flush_pre = 1'b1;
      count_nxt    = '0;
      skip_nxt     = 1'b0;
    end else if (skip_r) begin
      op.flush_pre = 1'b1;
      op.emit      = 1'b1;
      op.kind      = in_s.seg_kind;
      if (in_s.seg_kind == dcci_pkg::KIND_DMA) begin
        op.direction = in_s.direction;
        op.cluster   = in_s.cluster;
      end
      count_nxt = '0;
      skip_nxt  = 1'b0;
    end else if (in_s.seg_kind == dcci_pkg::KIND_DMA && in_s.direction == loop_dir) begin
      op.flush_pre = 1'b1;
      op.emit      = 1'b1;
      op.kind      = dcci_pkg::KIND_DMA;
      op.direction = in_s.direction;
      op.cluster   = in_s.cluster;
      count_nxt    = '0;
      skip_nxt     = 1'b1;
    end else if (in_s.seg_kind == dcci_pkg::KIND_DMA) begin
      if (count_r != '0 && in_s.direction != rdir_r) begin
        op.flush_pre = 1'b1;
        base         = '0;
      end
      op.append    = 1'b1;
      op.kind      = dcci_pkg::KIND_DMA;
      op.direction = in_s.direction;
      op.cluster   = in_s.cluster;
      rdir_nxt     = in_s.direction;
      if (base + 1'b1 == CW'(RUN_DEPTH)) begin
        op.flush_post = 1'b1;
        count_nxt     = '0;
      end else begin
        count_nxt = base + 1'b1;
      end
    end else begin
      op.flush_pre = 1'b1;
      op.emit      = 1'b1;
      op.kind      = dcci_pkg::KIND_OTHER;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rdir_r  <= '0;
      skip_r  <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      rdir_r  <= rdir_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

@@ hw/rtl/dcci_queue.sv @@
// ----------------------------------------------------------------------------
// dcci_queue
// Two-entry operation queue between front and back.
// ----------------------------------------------------------------------------
module dcci_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcci_pkg::op_t  push_op,
  output logic           can_push,
  input  logic           pop,
  output dcci_pkg::op_t  head_op,
  output logic           head_valid
);

  dcci_pkg::op_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign can_push   = (fill_r != 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && can_push;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/dcci_back.sv @@
// ----------------------------------------------------------------------------
// dcci_back
// Executes operations: run buffering, ordered or interleaved flush, pass-through.
// ----------------------------------------------------------------------------
module dcci_back #(
  parameter int RUN_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcci_pkg::op_t                 op,
  input  logic                          op_valid,
  output logic                          op_pop,
  input  logic [dcci_pkg::MASK_W-1:0]   mask,
  dcci_out_if.source                    out_m
);

  localparam int CW  = $clog2(RUN_DEPTH + 1);
  localparam int AW  = $clog2(RUN_DEPTH);
  localparam int NC  = dcci_pkg::CLUSTER_IDS;
  localparam int BW  = AW + dcci_pkg::CLU_W;
  localparam int AWD = dcci_pkg::CLU_W + dcci_pkg::PAYLOAD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                     st_r, st_nxt;
  dcci_pkg::op_t                  op_r, op_nxt;
  logic [CW-1:0]                  bcount_r, bcount_nxt;
  logic [dcci_pkg::DIR_W-1:0]     rdir_r, rdir_nxt;
  logic [CW-1:0]                  cnt_r [NC];
  logic [CW-1:0]                  cnt_nxt [NC];
  logic [CW-1:0]                  left_r, left_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic [AW-1:0]                  rr_r, rr_nxt;
  logic [dcci_pkg::CLU_W-1:0]     cc_r, cc_nxt;
  logic [dcci_pkg::CLU_W-1:0]     sel_r, sel_nxt;
  logic                           flast_r, flast_nxt;
  logic                           ilv_r, ilv_nxt;
  logic                           fl_r, fl_nxt;

  logic                           ov_r, ov_nxt;
  logic                           ok_r, ok_nxt;
  logic [dcci_pkg::DIR_W-1:0]     od_r, od_nxt;
  logic [dcci_pkg::CLU_W-1:0]     oc_r, oc_nxt;
  logic [dcci_pkg::PAYLOAD_W-1:0] op_pay_r, op_pay_nxt;
  logic                           ol_r, ol_nxt;

  logic                           found;
  logic [dcci_pkg::CLU_W-1:0]     fc;
  logic                           a_we, b_we;
  logic [AWD-1:0]                 a_rdata;
  logic [dcci_pkg::PAYLOAD_W-1:0] b_rdata;
  logic [BW-1:0]                  b_waddr;
  logic [CW-1:0]                  own_cnt;

  assign own_cnt = cnt_r[op_r.cluster];
  assign b_waddr = {own_cnt[AW-1:0], op_r.cluster};

  always_comb begin
    found = 1'b0;
    fc    = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (cnt_r[c] > CW'(rr_r) && dcci_pkg::CLU_W'(c) >= cc_r) begin
        found = 1'b1;
        fc    = dcci_pkg::CLU_W'(c);
      end
    end
  end

  dcci_ram #(.WIDTH(AWD), .DEPTH(RUN_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (bcount_r[AW-1:0]),
    .wdata ({op_r.cluster, op_r.payload}),
    .raddr (idx_r),
    .rdata (a_rdata)
  );

  dcci_ram #(.WIDTH(dcci_pkg::PAYLOAD_W), .DEPTH(RUN_DEPTH * NC)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (op_r.payload),
    .raddr ({rr_r, fc}),
    .rdata (b_rdata)
  );

  assign out_m.valid         = ov_r;
  assign out_m.out_kind      = ok_r;
  assign out_m.out_direction = od_r;
  assign out_m.out_cluster   = oc_r;
  assign out_m.out_payload   = op_pay_r;
  assign out_m.last          = ol_r;

  always_comb begin
    st_nxt     = st_r;
    op_nxt     = op_r;
    bcount_nxt = bcount_r;
    rdir_nxt   = rdir_r;
    cnt_nxt    = cnt_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    rr_nxt     = rr_r;
    cc_nxt     = cc_r;
    sel_nxt    = sel_r;
    flast_nxt  = flast_r;
    ilv_nxt    = ilv_r;
    fl_nxt     = fl_r;
    ov_nxt     = ov_r;
    ok_nxt     = ok_r;
    od_nxt     = od_r;
    oc_nxt     = oc_r;
    op_pay_nxt = op_pay_r;
    ol_nxt     = ol_r;
    op_pop     = 1'b0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          op_nxt = op;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (op_r.flush_pre || op_r.flush_post) begin
          if (op_r.flush_pre) begin
            op_nxt.flush_pre = 1'b0;
            flast_nxt        = !op_r.emit && !op_r.flush_post;
          end else begin
            op_nxt.flush_post = 1'b0;
            flast_nxt         = 1'b1;
          end
          if (op_r.flush_pre || !op_r.append) begin
            if (bcount_r != '0) begin
              fl_nxt   = 1'b1;
              left_nxt = bcount_r;
              idx_nxt  = '0;
              rr_nxt   = '0;
              cc_nxt   = '0;
              ilv_nxt  = mask[rdir_r];
              st_nxt   = S_ISSUE;
            end
          end else begin
            op_nxt.flush_post = 1'b1;
            flast_nxt         = flast_r;
            a_we              = 1'b1;
            b_we              = 1'b1;
            cnt_nxt[op_r.cluster] = own_cnt + 1'b1;
            bcount_nxt        = bcount_r + 1'b1;
            rdir_nxt          = op_r.direction;
            op_nxt.append     = 1'b0;
          end
        end else if (op_r.append) begin
          a_we                  = 1'b1;
          b_we                  = 1'b1;
          cnt_nxt[op_r.cluster] = own_cnt + 1'b1;
          bcount_nxt            = bcount_r + 1'b1;
          rdir_nxt              = op_r.direction;
          op_nxt.append         = 1'b0;
        end else if (op_r.emit) begin
          op_nxt.emit = 1'b0;
          fl_nxt      = 1'b0;
          ov_nxt      = 1'b1;
          ok_nxt      = op_r.kind;
          od_nxt      = op_r.direction;
          oc_nxt      = op_r.cluster;
          op_pay_nxt  = op_r.payload;
          ol_nxt      = 1'b1;
          st_nxt      = S_OUT;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_ISSUE: begin
        if (!ilv_r) begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = S_DATA;
        end else if (found) begin
          sel_nxt = fc;
          if (fc == dcci_pkg::CLU_W'(NC - 1)) begin
            rr_nxt = rr_r + 1'b1;
            cc_nxt = '0;
          end else begin
            cc_nxt = fc + 1'b1;
          end
          st_nxt = S_DATA;
        end else begin
          rr_nxt = rr_r + 1'b1;
          cc_nxt = '0;
        end
      end
      S_DATA: begin
        ov_nxt     = 1'b1;
        ok_nxt     = dcci_pkg::KIND_DMA;
        od_nxt     = rdir_r;
        oc_nxt     = ilv_r ? sel_r : a_rdata[AWD-1:dcci_pkg::PAYLOAD_W];
        op_pay_nxt = ilv_r ? b_rdata : a_rdata[dcci_pkg::PAYLOAD_W-1:0];
        ol_nxt     = flast_r && (left_r == CW'(1));
        left_nxt   = left_r - 1'b1;
        st_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_m.ready) begin
          ov_nxt = 1'b0;
          if (fl_r && left_r != '0) begin
            st_nxt = S_ISSUE;
          end else begin
            if (fl_r) begin
              fl_nxt     = 1'b0;
              bcount_nxt = '0;
              for (int c = 0; c < NC; c++) begin
                cnt_nxt[c] = '0;
              end
            end
            st_nxt = S_DISP;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      op_r     <= '0;
      bcount_r <= '0;
      rdir_r   <= '0;
      for (int c = 0; c < NC; c++) begin
        cnt_r[c] <= '0;
      end
      left_r   <= '0;
      fl_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      op_r     <= op_nxt;
      bcount_r <= bcount_nxt;
      rdir_r   <= rdir_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      fl_r     <= fl_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rr_r     <= rr_nxt;
    cc_r     <= cc_nxt;
    sel_r    <= sel_nxt;
    flast_r  <= flast_nxt;
    ilv_r    <= ilv_nxt;
    ok_r     <= ok_nxt;
    od_r     <= od_nxt;
    oc_r     <= oc_nxt;
    op_pay_r <= op_pay_nxt;
    ol_r     <= ol_nxt;
  end

endmodule

@@ hw/rtl/dma_command_cluster_interleaver_core.sv @@
// ----------------------------------------------------------------------------
// dma_command_cluster_interleaver_core
// Buffers same-direction DMA runs and flushes them in order or by cluster.
// ----------------------------------------------------------------------------
// The back end pops an op only once it has finished the last one; the queue holds up to
// two ops meanwhile. Dispatch handles the steps of an op (flush, append, emit) one by one;
// each flushed segment passes RAM read issue, data and output, an emitted one goes straight
// to output, and both wait in output while the receiver stalls; an interleaved flush adds
// an issue step for each round that ends below the top cluster id.
// Reset (rst_n low, synchronous) empties the run and queue, mask 0, loop_dir 7.
module dma_command_cluster_interleaver_core #(
  parameter int RUN_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  dcci_in_if.sink     in_s,
  dcci_out_if.source  out_m,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [dcci_pkg::MASK_W-1:0] mask_r;
  logic [dcci_pkg::DIR_W-1:0]  loop_r;
  logic                        wr;

  dcci_pkg::op_t fq_op, bq_op;
  logic          fq_valid, fq_ready, bq_valid, bq_pop;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == dcci_pkg::REG_LOOP) ?
                      {29'd0, loop_r} : {24'd0, mask_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      loop_r <= 3'd7;
    end else if (wr) begin
      if (cfg_paddr[2] == dcci_pkg::REG_MASK) begin
        mask_r <= cfg_pwdata[7:0];
      end else begin
        loop_r <= cfg_pwdata[2:0];
      end
    end
  end

  dcci_front #(.RUN_DEPTH(RUN_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .loop_dir (loop_r),
    .op       (fq_op),
    .op_valid (fq_valid),
    .op_ready (fq_ready)
  );

  dcci_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fq_valid),
    .push_op    (fq_op),
    .can_push   (fq_ready),
    .pop        (bq_pop),
    .head_op    (bq_op),
    .head_valid (bq_valid)
  );

  dcci_back #(.RUN_DEPTH(RUN_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (bq_op),
    .op_valid (bq_valid),
    .op_pop   (bq_pop),
    .mask     (mask_r),
    .out_m    (out_m)
  );

endmodule

@@ hw/rtl/dcci_checker.sv @@
// ----------------------------------------------------------------------------
// dcci_checker
// Port-level checks on the result stream and configuration port.
// ----------------------------------------------------------------------------
module dcci_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [2:0] out_direction,
  input logic [3:0] out_cluster,
  input logic       out_last,
  input logic       cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last) && $stable(out_kind))
    else $error("result dropped while stalled");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_direction == 3'd0 && out_cluster == 4'd0)
    else $error("non-DMA segment carries direction or cluster");

  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last)
    else $error("pass-through segment not marked last");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind dma_command_cluster_interleaver_core dcci_checker u_dcci_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_m.valid),
  .out_ready     (out_m.ready),
  .out_kind      (out_m.out_kind),
  .out_direction (out_m.out_direction),
  .out_cluster   (out_m.out_cluster),
  .out_last      (out_m.last),
  .cfg_pready    (cfg_pready)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the DMA command cluster interleaver. An in-bench model of the
// run buffer predicts every emitted segment; a scoreboard compares transfers
// field by field while both stream sides idle at random and the APB port
// switches mask and loop direction between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_MAX = 32;

  typedef struct {
    logic                           kind;
    logic [dcci_pkg::DIR_W-1:0]     direction;
    logic [dcci_pkg::CLU_W-1:0]     cluster;
    logic [dcci_pkg::PAYLOAD_W-1:0] payload;
    logic                           last;
  } seg_t;

  class segment_scoreboard;
    logic [dcci_pkg::MASK_W-1:0]    mask;
    logic [dcci_pkg::DIR_W-1:0]     loop_dir;
    logic [dcci_pkg::PAYLOAD_W-1:0] run_pay[RUN_MAX];
    logic [dcci_pkg::CLU_W-1:0]     run_clu[RUN_MAX];
    bit                             run_sent[RUN_MAX];
    int                             run_len;
    logic [dcci_pkg::DIR_W-1:0]     run_dir;
    bit                             skip_next;
    seg_t                           pending[$];
    int                             errors;
    int                             checked;
    int                             flushes;

    function new();
      mask = '0;
      loop_dir = 3'd7;
      run_len = 0;
      run_dir = '0;
      skip_next = 0;
      errors = 0;
      checked = 0;
      flushes = 0;
    endfunction

    function void push_seg(logic kind, logic [dcci_pkg::DIR_W-1:0] d,
                           logic [dcci_pkg::CLU_W-1:0] c,
                           logic [dcci_pkg::PAYLOAD_W-1:0] p);
      seg_t s;
      s.kind = kind;
      s.direction = (kind == dcci_pkg::KIND_OTHER) ? '0 : d;
      s.cluster = (kind == dcci_pkg::KIND_OTHER) ? '0 : c;
      s.payload = p;
      s.last = 1'b0;
      pending.insert(pending.size(), s);
    endfunction

    function void flush_run();
      int left;
      bit found;
      if (run_len > 0) flushes++;
      if (!mask[run_dir]) begin
        for (int i = 0; i < run_len; i++)
          push_seg(dcci_pkg::KIND_DMA, run_dir, run_clu[i], run_pay[i]);
      end else begin
        left = run_len;
        while (left > 0) begin
          for (int c = 0; c < dcci_pkg::CLUSTER_IDS; c++) begin
            found = 0;
            for (int i = 0; i < run_len && !found; i++) begin
              if (!run_sent[i] && run_clu[i] == c) begin
                run_sent[i] = 1;
                push_seg(dcci_pkg::KIND_DMA, run_dir, run_clu[i], run_pay[i]);
                left--;
                found = 1;
              end
            end
          end
        end
      end
      for (int i = 0; i < RUN_MAX; i++) run_sent[i] = 0;
      run_len = 0;
    endfunction

    function void note_input(logic cmd, logic kind, logic [dcci_pkg::DIR_W-1:0] d,
                             logic [dcci_pkg::CLU_W-1:0] c,
                             logic [dcci_pkg::PAYLOAD_W-1:0] p);
      int before_n;
      before_n = pending.size();
      if (cmd == dcci_pkg::CMD_END) begin
        flush_run();
        skip_next = 0;
      end else if (skip_next) begin
        skip_next = 0;
        flush_run();
        push_seg(kind, d, c, p);
      end else if (kind == dcci_pkg::KIND_DMA && d == loop_dir) begin
        flush_run();
        push_seg(dcci_pkg::KIND_DMA, d, c, p);
        skip_next = 1;
      end else if (kind == dcci_pkg::KIND_DMA) begin
        if (run_len > 0 && d != run_dir) flush_run();
        run_dir = d;
        run_pay[run_len] = p;
        run_clu[run_len] = c;
        run_sent[run_len] = 0;
        run_len++;
        if (run_len >= RUN_MAX) flush_run();
      end else begin
        flush_run();
        push_seg(dcci_pkg::KIND_OTHER, '0, '0, p);
      end
      if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(seg_t got);
      seg_t exp_s;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transfer payload=%h", got.payload));
        return;
      end
      exp_s = pending[0];
      pending.delete(0);
      if (got.kind !== exp_s.kind || got.direction !== exp_s.direction ||
          got.cluster !== exp_s.cluster || got.payload !== exp_s.payload ||
          got.last !== exp_s.last)
        report($sformatf("got k%b d%0d c%0d p%h l%b, want k%b d%0d c%0d p%h l%b",
                         got.kind, got.direction, got.cluster, got.payload, got.last,
                         exp_s.kind, exp_s.direction, exp_s.cluster, exp_s.payload,
                         exp_s.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dcci_in_if  in_if ();
  dcci_out_if out_if ();

  dma_command_cluster_interleaver_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (in_if.sink),
    .out_m       (out_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  segment_scoreboard sb = new();
  int burst_left;
  int sent;
  int stall_mode = 0;
  int stall_cnt = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

  // input monitor
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_input(in_if.cmd, in_if.seg_kind, in_if.direction, in_if.cluster,
                    in_if.payload);
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    seg_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind = out_if.out_kind;
      got.direction = out_if.out_direction;
      got.cluster = out_if.out_cluster;
      got.payload = out_if.out_payload;
      got.last = out_if.last;
      sb.check_result(got);
    end
    stall_cnt++;
    if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (!rst_n) begin
      out_if.ready <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= (stall_cnt % 5 != 0);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic cfg_write(logic addr_sel, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {addr_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr_sel == dcci_pkg::REG_MASK) sb.mask = value[dcci_pkg::MASK_W-1:0];
    else sb.loop_dir = value[dcci_pkg::DIR_W-1:0];
  endtask

  task automatic send_item(logic cmd, logic kind, logic [2:0] d, logic [3:0] c,
                           logic [63:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.seg_kind  <= kind;
    in_if.direction <= d;
    in_if.cluster   <= c;
    in_if.payload   <= p;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic drain();
    int guard;
    in_if.valid <= 1'b0;
    burst_left = 0;
    guard = 0;
    while (sb.pending.size() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n_items);
    int sel;
    int len;
    logic [2:0] d;
    int ncl;
    int base;
    base = sent;
    while (sent - base < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        d = 3'($urandom_range(0, 7));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 8);
        ncl = $urandom_range(1, 16);
        repeat (len)
          send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, d,
                    4'($urandom_range(0, ncl - 1)), rnd64());
      end else if (sel < 72) begin
        send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, sb.loop_dir,
                  4'($urandom_range(0, 15)), rnd64());
        send_item(dcci_pkg::CMD_PUSH, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15)), rnd64());
      end else if (sel < 82) begin
        send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_OTHER, 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15)), rnd64());
      end else if (sel < 92) begin
        send_item(dcci_pkg::CMD_END, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15)), rnd64());
      end else begin
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), rnd64());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = dcci_pkg::CMD_PUSH;
    in_if.seg_kind = dcci_pkg::KIND_DMA;
    in_if.direction = '0;
    in_if.cluster = '0;
    in_if.payload = '0;
    burst_left = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: interleaved run, breaks, loop segments, end of list
    cfg_write(dcci_pkg::REG_MASK, 32'h0000_00ff);
    cfg_write(dcci_pkg::REG_LOOP, 32'd7);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd2, 4'd5, 64'h0);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd2, 4'd15, 64'hffff_ffff_ffff_ffff);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd2, 4'd5, 64'h5555_aaaa_5555_aaaa);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd2, 4'd0, 64'haaaa_5555_aaaa_5555);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd0, 4'd3, 64'h1);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_OTHER, 3'd6, 4'd9, 64'h8000_0000_0000_0000);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd7, 4'd4, 64'h7);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_OTHER, 3'd5, 4'd9, 64'h9);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd7, 4'd1, 64'hb);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd7, 4'd2, 64'hc);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd4, 4'd15, 64'hd);
    send_item(dcci_pkg::CMD_END, dcci_pkg::KIND_OTHER, 3'd7, 4'd15, 64'hffff_ffff_ffff_ffff);
    send_item(dcci_pkg::CMD_END, dcci_pkg::KIND_DMA, 3'd0, 4'd0, 64'h0);
    drain();
    cfg_write(dcci_pkg::REG_MASK, 32'h0000_0000);
    cfg_write(dcci_pkg::REG_LOOP, 32'd0);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd3, 4'd8, 64'h11);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd3, 4'd1, 64'h22);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd0, 4'd1, 64'h33);
    send_item(dcci_pkg::CMD_PUSH, dcci_pkg::KIND_DMA, 3'd1, 4'd2, 64'h44);
    send_item(dcci_pkg::CMD_END, dcci_pkg::KIND_DMA, 3'd0, 4'd0, 64'h0);
    drain();

    // random phases at several settings
    random_phase(100);
    drain();
    cfg_write(dcci_pkg::REG_MASK, 32'h0000_00ff);
    cfg_write(dcci_pkg::REG_LOOP, 32'd7);
    random_phase(100);
    drain();
    cfg_write(dcci_pkg::REG_MASK, $urandom_range(0, 255));
    cfg_write(dcci_pkg::REG_LOOP, $urandom_range(0, 7));
    random_phase(100);
    drain();
    cfg_write(dcci_pkg::REG_MASK, $urandom_range(0, 255));
    cfg_write(dcci_pkg::REG_LOOP, 32'd0);
    random_phase(100);
    send_item(dcci_pkg::CMD_END, dcci_pkg::KIND_DMA, 3'd0, 4'd0, 64'h0);
    drain();

    $display("Covered %0d input transfers, %0d result transfers, %0d run flushes",
             sent, sb.checked, sb.flushes);
    $display("across in-order and interleaved settings with random source gaps and sink stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
